[rtl/mvc_pkg.sv]
// shared types and constants for the multi-voice chorus delay mix
package mvc_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int DELAY_W    = 20;
  localparam int GAIN_W     = 16;
  localparam int FRAC_W     = 8;
  localparam int MASK_W     = 4;
  localparam int PORT_VOICES = 4;
  localparam int MUL_A_W    = 26;
  localparam int MUL_B_W    = 17;
  localparam int ACC_W      = 46;
  localparam int ROUND_SHIFT = 20;
  localparam int SAMPLE_MAX = 32767;
  localparam int SAMPLE_MIN = -32768;
  localparam int FRAME_W    = 2 * SAMPLE_W;

  typedef struct packed {
    logic [SAMPLE_W-1:0] right;
    logic [SAMPLE_W-1:0] left;
  } frame_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WRITE,
    S_VOICE,
    S_RD1,
    S_M0L,
    S_M1L,
    S_GL,
    S_M0R,
    S_M1R,
    S_GR,
    S_ROUND
  } state_e;

  function automatic logic signed [MUL_A_W-1:0] sext_sample(input logic [SAMPLE_W-1:0] s);
    sext_sample = {{(MUL_A_W - SAMPLE_W){s[SAMPLE_W-1]}}, s};
  endfunction

endpackage

[rtl/mvc_ram.sv]
// generic single-write, single-read ram with registered read data
module mvc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/mvc_mac.sv]
// shared signed-by-unsigned multiply-accumulate unit
module mvc_mac (
  input  logic signed [mvc_pkg::MUL_A_W-1:0] a_i,
  input  logic        [mvc_pkg::MUL_B_W-1:0] b_i,
  input  logic signed [mvc_pkg::ACC_W-1:0]   c_i,
  output logic signed [mvc_pkg::ACC_W-1:0]   p_o
);

  logic signed [mvc_pkg::MUL_A_W+mvc_pkg::MUL_B_W:0] prod;

  assign prod = a_i * $signed({1'b0, b_i});
  assign p_o  = c_i + mvc_pkg::ACC_W'(prod);

endmodule

[rtl/multi_voice_chorus_delay_mix.sv]
// multi-voice chorus: fractional delay taps, gain and saturating stereo mix
// an input word is written to the ring, then each enabled voice is read, interpolated and
// weighted, then both sums are rounded; in_stall_o stays high until the mix word is registered
// throughput is bound by the single shared multiply-accumulate unit, six passes per enabled voice
// reset clears control state and the history fill count; unwritten history reads as zero
// there is no clearing pass, so the block takes a word right after reset
module multi_voice_chorus_delay_mix #(
  parameter int VOICES = 4,
  parameter int DEPTH  = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mvc_pkg::MASK_W-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [mvc_pkg::SAMPLE_W-1:0]  sample_left_i,
  input  logic [mvc_pkg::SAMPLE_W-1:0]  sample_right_i,
  input  logic [mvc_pkg::DELAY_W-1:0]   delay_voice0_i,
  input  logic [mvc_pkg::DELAY_W-1:0]   delay_voice1_i,
  input  logic [mvc_pkg::DELAY_W-1:0]   delay_voice2_i,
  input  logic [mvc_pkg::DELAY_W-1:0]   delay_voice3_i,
  input  logic [mvc_pkg::GAIN_W-1:0]    gain_voice0_i,
  input  logic [mvc_pkg::GAIN_W-1:0]    gain_voice1_i,
  input  logic [mvc_pkg::GAIN_W-1:0]    gain_voice2_i,
  input  logic [mvc_pkg::GAIN_W-1:0]    gain_voice3_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [mvc_pkg::SAMPLE_W-1:0]  mix_left_o,
  output logic [mvc_pkg::SAMPLE_W-1:0]  mix_right_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);
  localparam int CW = $clog2(VOICES + 1);
  localparam logic [mvc_pkg::DELAY_W-1:0] DMAX = mvc_pkg::DELAY_W'((DEPTH - 1) * 256);
  localparam int QW = mvc_pkg::ACC_W + 1 - mvc_pkg::ROUND_SHIFT;

  function automatic logic [mvc_pkg::SAMPLE_W-1:0] round_sat(
    input logic signed [mvc_pkg::ACC_W-1:0] acc
  );
    logic signed [mvc_pkg::ACC_W:0] biased;
    logic signed [QW-1:0]           q;
    biased = (mvc_pkg::ACC_W + 1)'(acc) + (mvc_pkg::ACC_W + 1)'(1 << (mvc_pkg::ROUND_SHIFT - 1));
    q = biased[mvc_pkg::ACC_W:mvc_pkg::ROUND_SHIFT];
    if (q > QW'(mvc_pkg::SAMPLE_MAX)) begin
      round_sat = mvc_pkg::SAMPLE_W'(mvc_pkg::SAMPLE_MAX);
    end else if (q < QW'(mvc_pkg::SAMPLE_MIN)) begin
      round_sat = mvc_pkg::SAMPLE_W'(mvc_pkg::SAMPLE_MIN);
    end else begin
      round_sat = q[mvc_pkg::SAMPLE_W-1:0];
    end
  endfunction

  mvc_pkg::state_e state_q, state_d;

  logic [mvc_pkg::MASK_W-1:0]  mask_q;
  logic [AW-1:0]               wp_q;
  logic [FW-1:0]               fill_q;
  logic [CW-1:0]               v_q;
  mvc_pkg::frame_t             frame_q;
  logic [mvc_pkg::DELAY_W-1:0] delay_q [mvc_pkg::PORT_VOICES];
  logic [mvc_pkg::GAIN_W-1:0]  gain_q  [mvc_pkg::PORT_VOICES];
  logic [mvc_pkg::FRAC_W-1:0]  f_q;
  logic [AW-1:0]               i0_q;
  logic                        x0_ok_q;
  logic                        x1_ok_q;
  mvc_pkg::frame_t             x0_q;
  mvc_pkg::frame_t             x1_q;
  logic signed [mvc_pkg::MUL_A_W-1:0] interp_q;
  logic signed [mvc_pkg::ACC_W-1:0]   acc_l_q;
  logic signed [mvc_pkg::ACC_W-1:0]   acc_r_q;
  logic [mvc_pkg::SAMPLE_W-1:0] mix_l_q;
  logic [mvc_pkg::SAMPLE_W-1:0] mix_r_q;
  logic                         out_valid_q;

  logic                        in_accept;
  logic                        out_free;
  logic [1:0]                  sel;
  logic                        voice_en;
  logic                        voices_done;
  logic [mvc_pkg::DELAY_W-1:0] d_clamp;
  logic [AW-1:0]               k;
  logic [mvc_pkg::FRAC_W-1:0]  f;
  logic [AW-1:0]               i0;
  logic [AW-1:0]               i1;
  logic                        x0_ok;
  logic                        x1_ok;
  logic [AW-1:0]               raddr;
  mvc_pkg::frame_t             rdata;
  logic signed [mvc_pkg::MUL_A_W-1:0] mac_a;
  logic [mvc_pkg::MUL_B_W-1:0]        mac_b;
  logic signed [mvc_pkg::ACC_W-1:0]   mac_c;
  logic signed [mvc_pkg::ACC_W-1:0]   mac_p;
  logic [mvc_pkg::MUL_B_W-1:0]        w0;
  logic [mvc_pkg::MUL_B_W-1:0]        w1;
  logic [mvc_pkg::MUL_B_W-1:0]        g;

  assign in_accept   = in_valid_i && (state_q == mvc_pkg::S_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign sel         = (v_q < CW'(VOICES)) ? 2'(v_q) : 2'd0;
  assign voice_en    = mask_q[sel];
  assign voices_done = (v_q == CW'(VOICES));

  // delay clamp and ring addressing for the current voice
  assign d_clamp = (delay_q[sel] > DMAX) ? DMAX : delay_q[sel];
  assign k       = AW'(d_clamp[mvc_pkg::DELAY_W-1:mvc_pkg::FRAC_W]);
  assign f       = d_clamp[mvc_pkg::FRAC_W-1:0];
  assign i0      = (wp_q >= k) ? (wp_q - k) : AW'((AW + 1)'(wp_q) + (AW + 1)'(DEPTH)
                                                  - (AW + 1)'(k));
  assign i1      = (i0_q == '0) ? AW'(DEPTH - 1) : (i0_q - 1'b1);
  assign x0_ok   = (FW'(k) < fill_q);
  assign x1_ok   = (f != '0) && (((FW + 1)'(k) + 1'b1) < (FW + 1)'(fill_q));
  assign raddr   = (state_q == mvc_pkg::S_RD1) ? i1 : i0;

  assign w0 = mvc_pkg::MUL_B_W'(9'd256 - 9'(f_q));
  assign w1 = mvc_pkg::MUL_B_W'(f_q);
  assign g  = mvc_pkg::MUL_B_W'(gain_q[sel]);

  mvc_ram #(
    .WIDTH (mvc_pkg::FRAME_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (state_q == mvc_pkg::S_WRITE),
    .waddr_i (wp_q),
    .wdata_i (frame_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  mvc_mac u_mac (
    .a_i (mac_a),
    .b_i (mac_b),
    .c_i (mac_c),
    .p_o (mac_p)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mvc_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    mac_a   = '0;
    mac_b   = '0;
    mac_c   = '0;
    case (state_q)
      mvc_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = mvc_pkg::S_WRITE;
        end
      end
      mvc_pkg::S_WRITE: state_d = mvc_pkg::S_VOICE;
      mvc_pkg::S_VOICE: begin
        if (voices_done) begin
          state_d = mvc_pkg::S_ROUND;
        end else if (voice_en) begin
          state_d = mvc_pkg::S_RD1;
        end
      end
      mvc_pkg::S_RD1: state_d = mvc_pkg::S_M0L;
      mvc_pkg::S_M0L: begin
        mac_a   = mvc_pkg::sext_sample(x0_q.left);
        mac_b   = w0;
        state_d = mvc_pkg::S_M1L;
      end
      mvc_pkg::S_M1L: begin
        mac_a   = mvc_pkg::sext_sample(x1_q.left);
        mac_b   = w1;
        mac_c   = mvc_pkg::ACC_W'(interp_q);
        state_d = mvc_pkg::S_GL;
      end
      mvc_pkg::S_GL: begin
        mac_a   = interp_q;
        mac_b   = g;
        mac_c   = acc_l_q;
        state_d = mvc_pkg::S_M0R;
      end
      mvc_pkg::S_M0R: begin
        mac_a   = mvc_pkg::sext_sample(x0_q.right);
        mac_b   = w0;
        state_d = mvc_pkg::S_M1R;
      end
      mvc_pkg::S_M1R: begin
        mac_a   = mvc_pkg::sext_sample(x1_q.right);
        mac_b   = w1;
        mac_c   = mvc_pkg::ACC_W'(interp_q);
        state_d = mvc_pkg::S_GR;
      end
      mvc_pkg::S_GR: begin
        mac_a   = interp_q;
        mac_b   = g;
        mac_c   = acc_r_q;
        state_d = mvc_pkg::S_VOICE;
      end
      mvc_pkg::S_ROUND: begin
        if (out_free) begin
          state_d = mvc_pkg::S_IDLE;
        end
      end
      default: state_d = mvc_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      wp_q        <= '0;
      fill_q      <= '0;
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mask_q <= cfg_wdata_i;
      end
      if (state_q == mvc_pkg::S_WRITE) begin
        if (fill_q != FW'(DEPTH)) begin
          fill_q <= fill_q + 1'b1;
        end
        v_q <= '0;
      end
      if ((state_q == mvc_pkg::S_VOICE && !voices_done && !voice_en) ||
          state_q == mvc_pkg::S_GR) begin
        v_q <= v_q + 1'b1;
      end
      // pointer moves on once all taps of the word are read
      if (state_q == mvc_pkg::S_ROUND && out_free) begin
        wp_q        <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      frame_q    <= '{right: sample_right_i, left: sample_left_i};
      delay_q[0] <= delay_voice0_i;
      delay_q[1] <= delay_voice1_i;
      delay_q[2] <= delay_voice2_i;
      delay_q[3] <= delay_voice3_i;
      gain_q[0]  <= gain_voice0_i;
      gain_q[1]  <= gain_voice1_i;
      gain_q[2]  <= gain_voice2_i;
      gain_q[3]  <= gain_voice3_i;
    end
    case (state_q)
      mvc_pkg::S_WRITE: begin
        acc_l_q <= '0;
        acc_r_q <= '0;
      end
      mvc_pkg::S_VOICE: begin
        f_q     <= f;
        i0_q    <= i0;
        x0_ok_q <= x0_ok;
        x1_ok_q <= x1_ok;
      end
      mvc_pkg::S_RD1: x0_q <= x0_ok_q ? rdata : '0;
      mvc_pkg::S_M0L: begin
        x1_q     <= x1_ok_q ? rdata : '0;
        interp_q <= mac_p[mvc_pkg::MUL_A_W-1:0];
      end
      mvc_pkg::S_M1L, mvc_pkg::S_M0R, mvc_pkg::S_M1R: begin
        interp_q <= mac_p[mvc_pkg::MUL_A_W-1:0];
      end
      mvc_pkg::S_GL: acc_l_q <= mac_p;
      mvc_pkg::S_GR: acc_r_q <= mac_p;
      mvc_pkg::S_ROUND: begin
        if (out_free) begin
          mix_l_q <= round_sat(acc_l_q);
          mix_r_q <= round_sat(acc_r_q);
        end
      end
      default: ;
    endcase
  end

  assign in_stall_o  = (state_q != mvc_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign mix_left_o  = mix_l_q;
  assign mix_right_o = mix_r_q;

  a_accept_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q == mvc_pkg::S_WRITE)
    else $error("accepted word did not reach the ring write");

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(DEPTH))
    else $error("history fill count beyond ring depth");

  a_wp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q <= AW'(DEPTH - 1))
    else $error("write pointer outside ring");

  a_voice_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q <= CW'(VOICES))
    else $error("voice counter overran");

  a_round_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mvc_pkg::S_ROUND && out_free) |=> out_valid_q && state_q == mvc_pkg::S_IDLE)
    else $error("mix word not presented after rounding");

endmodule

[bench/tb_multi_voice_chorus_delay_mix.sv]
`timescale 1ns / 1ps
// self-checking testbench for the multi-voice chorus delay mix, directed table then random frames
module tb_multi_voice_chorus_delay_mix;

  localparam int VOICES = 4;
  localparam int DEPTH = 4096;
  localparam longint DLY_CLAMP = longint'(DEPTH - 1) * 256;
  localparam int DRAIN_CYCLES = 60;
  localparam int PHASES = 19;
  localparam int PHASE_WORDS = 100;

  typedef logic [mvc_pkg::SAMPLE_W-1:0] sample_t;
  typedef logic [3:0][mvc_pkg::DELAY_W-1:0] delay_vec_t;
  typedef logic [3:0][mvc_pkg::GAIN_W-1:0] gain_vec_t;

  typedef struct packed {
    gain_vec_t gain;
    delay_vec_t delay;
    sample_t right;
    sample_t left;
  } frame_word_t;

  typedef struct packed {
    sample_t right;
    sample_t left;
  } mix_t;

  typedef struct packed {
    logic [mvc_pkg::MASK_W-1:0] mask;
    logic typed;
    mix_t mix;
    frame_word_t word;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [mvc_pkg::MASK_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_stall;
  sample_t sample_left;
  sample_t sample_right;
  delay_vec_t delay_v;
  gain_vec_t gain_v;
  logic out_valid;
  logic out_stall;
  sample_t mix_left;
  sample_t mix_right;

  mvc_pkg::frame_t hist_ring [DEPTH];
  int hist_wp;
  logic [mvc_pkg::MASK_W-1:0] model_mask;
  mix_t mix_pending [$];
  dir_row_t dir_rows [$];
  int mismatches = 0;
  bit quiet = 1'b0;

  multi_voice_chorus_delay_mix #(
    .VOICES(VOICES),
    .DEPTH (DEPTH)
  ) i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .sample_left_i (sample_left),
    .sample_right_i(sample_right),
    .delay_voice0_i(delay_v[0]),
    .delay_voice1_i(delay_v[1]),
    .delay_voice2_i(delay_v[2]),
    .delay_voice3_i(delay_v[3]),
    .gain_voice0_i (gain_v[0]),
    .gain_voice1_i (gain_v[1]),
    .gain_voice2_i (gain_v[2]),
    .gain_voice3_i (gain_v[3]),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .mix_left_o    (mix_left),
    .mix_right_o   (mix_right)
  );

  always #5 clk = ~clk;

  function automatic sample_t round_to_sample(input longint acc);
    longint q;
    q = (acc + (longint'(1) << 19)) >>> mvc_pkg::ROUND_SHIFT;
    if (q > mvc_pkg::SAMPLE_MAX) q = mvc_pkg::SAMPLE_MAX;
    if (q < mvc_pkg::SAMPLE_MIN) q = mvc_pkg::SAMPLE_MIN;
    return q[mvc_pkg::SAMPLE_W-1:0];
  endfunction

  // writes the frame into the history, then sums the interpolated taps
  function automatic mix_t chorus_mix(input frame_word_t w);
    longint acc_l, acc_r, d, k, f, g, sl, sr;
    int v, i0, i1;
    mix_t m;
    acc_l = 0;
    acc_r = 0;
    hist_ring[hist_wp] = {w.right, w.left};
    for (v = 0; v < VOICES; v++) begin
      if (model_mask[v]) begin
        d = longint'(w.delay[v]);
        if (d > DLY_CLAMP) d = DLY_CLAMP;
        k = d >> 8;
        f = d & 255;
        g = longint'(w.gain[v]);
        i0 = int'((longint'(hist_wp) + DEPTH - k) % DEPTH);
        sl = longint'($signed(hist_ring[i0].left)) * (256 - f);
        sr = longint'($signed(hist_ring[i0].right)) * (256 - f);
        if (f != 0) begin
          i1 = int'((longint'(hist_wp) + DEPTH - k - 1) % DEPTH);
          sl += longint'($signed(hist_ring[i1].left)) * f;
          sr += longint'($signed(hist_ring[i1].right)) * f;
        end
        acc_l += sl * g;
        acc_r += sr * g;
      end
    end
    hist_wp = (hist_wp + 1) % DEPTH;
    m.left = round_to_sample(acc_l);
    m.right = round_to_sample(acc_r);
    return m;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 20);
    return $urandom_range(30, 90);
  endfunction

  function automatic sample_t rand_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return sample_t'($urandom);
    if (r < 75) return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    return sample_t'($urandom_range(0, 512) - 256);
  endfunction

  function automatic logic [mvc_pkg::DELAY_W-1:0] rand_delay();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return {12'($urandom_range(0, 15)), 8'($urandom)};
    if (r < 50) return {12'($urandom_range(0, 31)), 8'h00};
    if (r < 65) return {12'($urandom_range(0, 511)), 8'($urandom)};
    if (r < 80) return 20'($urandom);
    if (r < 90) return 20'(20'hFFF00 - $urandom_range(0, 511));
    return 20'(20'hFFEFF + $urandom_range(0, 256));
  endfunction

  function automatic logic [mvc_pkg::GAIN_W-1:0] rand_gain();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return 16'($urandom);
    if (r < 50) return 16'($urandom_range(0, 8191));
    if (r < 60) return 16'hFFFF;
    if (r < 65) return 16'h0000;
    return 16'($urandom_range(0, 2047));
  endfunction

  function automatic void add_row(input logic [3:0] mask, input sample_t left, right,
                                  input delay_vec_t dly, input gain_vec_t gn,
                                  input logic typed, input sample_t el, er);
    dir_row_t row;
    row.mask = mask;
    row.typed = typed;
    row.mix = {er, el};
    row.word = {gn, dly, right, left};
    dir_rows.push_back(row);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic drive_word(input frame_word_t w, input logic typed, input mix_t typed_mix);
    int gap;
    mix_t m;
    gap = quiet ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_left <= w.left;
    sample_right <= w.right;
    delay_v <= w.delay;
    gain_v <= w.gain;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    m = chorus_mix(w);
    mix_pending.push_back(typed ? typed_mix : m);
  endtask

  task automatic settle_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (mix_pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mask(input logic [mvc_pkg::MASK_W-1:0] m);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we <= 1'b0;
    model_mask = m;
  endtask

  always @(posedge clk) begin : mix_monitor
    mix_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (mix_pending.size() == 0) begin
        report_mismatch("mix word with no frame pending");
      end else begin
        want = mix_pending.pop_front();
        if (mix_left !== want.left)
          report_mismatch($sformatf("mix_left expected %0d got %0d",
                                    $signed(want.left), $signed(mix_left)));
        if (mix_right !== want.right)
          report_mismatch($sformatf("mix_right expected %0d got %0d",
                                    $signed(want.right), $signed(mix_right)));
      end
    end
  end

  initial begin : out_stall_gen
    int stall_left;
    stall_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (!quiet && $urandom_range(0, 9) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin : watchdog
    #20ms;
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    frame_word_t w;
    int p, n, v;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    sample_left = '0;
    sample_right = '0;
    delay_v = '0;
    gain_v = '0;
    foreach (hist_ring[i]) hist_ring[i] = '0;
    hist_wp = 0;
    model_mask = '0;

    // no voice enabled
    add_row(4'h0, 16'h7FFF, 16'h8000, {4{20'h00000}}, {4{16'hFFFF}}, 1'b1, 16'h0, 16'h0);
    add_row(4'h0, 16'h8000, 16'h7FFF, {4{20'hFFFFF}}, {4{16'hFFFF}}, 1'b1, 16'h0, 16'h0);
    // voice 0 alone, other voices ignored
    add_row(4'h1, 16'd1000, -16'sd1000, {{3{20'hFFFFF}}, 20'h00000},
            {{3{16'hFFFF}}, 16'h1000}, 1'b1, 16'd1000, -16'sd1000);
    add_row(4'h1, 16'h7FFF, 16'h8000, {{3{20'hFFFFF}}, 20'h00000},
            {{3{16'hFFFF}}, 16'h1000}, 1'b1, 16'h7FFF, 16'h8000);
    add_row(4'h1, 16'd5, 16'd6, {{3{20'hFFFFF}}, 20'h00100},
            {{3{16'hFFFF}}, 16'h1000}, 1'b1, 16'h7FFF, 16'h8000);
    // rounding ties go toward plus infinity
    add_row(4'h1, 16'd1, -16'sd1, {{3{20'hFFFFF}}, 20'h00000},
            {{3{16'hFFFF}}, 16'h0800}, 1'b1, 16'd1, 16'd0);
    add_row(4'h1, 16'd3, -16'sd3, {{3{20'hFFFFF}}, 20'h00000},
            {{3{16'hFFFF}}, 16'h0800}, 1'b1, 16'd2, -16'sd1);
    // clamped and large delays land on unwritten history; then short fractional delays and zero gain
    add_row(4'h1, 16'd12345, -16'sd23456, {{3{20'h00000}}, 20'hFFFFF},
            {{3{16'hFFFF}}, 16'h1000}, 1'b1, 16'd0, 16'd0);
    add_row(4'h1, -16'sd7, 16'd7, {{3{20'h00000}}, 20'hFFF00},
            {{3{16'hFFFF}}, 16'h1000}, 1'b1, 16'd0, 16'd0);
    add_row(4'h1, -16'sd20000, 16'd20000, {{3{20'h00000}}, 20'h00180},
            {{3{16'hFFFF}}, 16'h1000}, 1'b0, 16'd0, 16'd0);
    add_row(4'h1, 16'h4000, 16'hC000, {{3{20'h00000}}, 20'h000FF},
            {{3{16'hFFFF}}, 16'h2345}, 1'b0, 16'd0, 16'd0);
    add_row(4'h1, 16'd1, 16'd1, {{3{20'h00000}}, 20'hFFEFF},
            {{3{16'hFFFF}}, 16'h1000}, 1'b0, 16'd0, 16'd0);
    add_row(4'h1, 16'h7FFF, 16'h8000, {{3{20'h00000}}, 20'h00203},
            {{3{16'hFFFF}}, 16'h0000}, 1'b1, 16'd0, 16'd0);
    // all voices, saturation both ways, then mixed delays and partial voice masks
    add_row(4'hF, 16'h7FFF, 16'h7FFF, {4{20'h00000}}, {4{16'hFFFF}}, 1'b1, 16'h7FFF, 16'h7FFF);
    add_row(4'hF, 16'h8000, 16'h8000, {4{20'h00000}}, {4{16'hFFFF}}, 1'b1, 16'h8000, 16'h8000);
    add_row(4'hF, 16'd1234, -16'sd4321, {20'h00380, 20'h00201, 20'h00100, 20'h00080},
            {16'h1000, 16'h0800, 16'h3000, 16'hFFFF}, 1'b0, 16'd0, 16'd0);
    add_row(4'hA, -16'sd1, 16'd1, {20'h00500, 20'hFFFFF, 20'h00240, 20'h00000},
            {16'h4000, 16'hFFFF, 16'h1800, 16'hFFFF}, 1'b0, 16'd0, 16'd0);
    add_row(4'h5, 16'd30000, -16'sd30000, {20'hFFFFF, 20'h00700, 20'h000C0, 20'h00601},
            {16'hFFFF, 16'h7000, 16'h0FFF, 16'h2000}, 1'b0, 16'd0, 16'd0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].mask != model_mask) begin
        settle_idle();
        write_mask(dir_rows[i].mask);
      end
      drive_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].mix);
    end

    for (p = 0; p < PHASES; p++) begin
      settle_idle();
      quiet = (p % 6 == 4);
      if (p == 0) write_mask(4'hF);
      else if (p == 1) write_mask(4'h0);
      else if (p == 2) write_mask(4'h1);
      else write_mask(4'($urandom_range(0, 15)));
      for (n = 0; n < PHASE_WORDS; n++) begin
        w.left = rand_sample();
        w.right = rand_sample();
        for (v = 0; v < 4; v++) begin
          w.delay[v] = rand_delay();
          w.gain[v] = rand_gain();
        end
        drive_word(w, 1'b0, '0);
      end
    end

    settle_idle();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
rtl/mvc_pkg.sv
rtl/mvc_ram.sv
rtl/mvc_mac.sv
rtl/multi_voice_chorus_delay_mix.sv
bench/tb_multi_voice_chorus_delay_mix.sv
